@@ sv/tsc_pkg.sv @@
package tsc_pkg;

    // Field and coordinate widths
    localparam int COORD_BITS  = 12;
    localparam int VALUE_BITS  = 12;
    localparam int TAP_BITS    = 12;
    localparam int RADIUS_BITS = 12;

    // Widths of the squared travel and the squared radius
    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int DIST_BITS = SQ_BITS + 1;
    localparam int RAD2_BITS = 2 * RADIUS_BITS;
    localparam int CMP_BITS  = (DIST_BITS > RAD2_BITS) ? DIST_BITS : RAD2_BITS;

    // Register reset values
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(50);
    localparam logic [RAD2_BITS-1:0]   RAD2_RESET   = RAD2_BITS'(50 * 50);

    // Event classes on the input channel
    typedef enum logic [1:0] {
        EV_OTHER = 2'd0,
        EV_ABS_X = 2'd1,
        EV_ABS_Y = 2'd2,
        EV_TOUCH = 2'd3
    } event_class_t;

    // Key states carried by a touch event
    localparam logic [VALUE_BITS-1:0] KEY_RELEASE = VALUE_BITS'(0);
    localparam logic [VALUE_BITS-1:0] KEY_PRESS   = VALUE_BITS'(1);

    // Gesture codes on the result channel
    typedef enum logic [2:0] {
        GEST_TAP   = 3'd0,
        GEST_RIGHT = 3'd1,
        GEST_LEFT  = 3'd2,
        GEST_DOWN  = 3'd3,
        GEST_UP    = 3'd4
    } gesture_t;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [TAP_BITS-1:0]   tap_t;

    // Everything the classifier needs to know about one release
    typedef struct packed {
        coord_t abs_dx;
        coord_t abs_dy;
        logic   dx_neg;
        logic   dy_pos;
        tap_t   tap_x;
        tap_t   tap_y;
    } release_t;

    // Keep the low COORD_BITS of an event value, zero-filling if narrower.
    function automatic coord_t to_coord(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS+COORD_BITS-1:0] ext;
        ext = {{COORD_BITS{1'b0}}, value};
        return ext[COORD_BITS-1:0];
    endfunction

    // Keep the low TAP_BITS of a coordinate, zero-filling if narrower.
    function automatic tap_t to_tap(input coord_t coord);
        logic [COORD_BITS+TAP_BITS-1:0] ext;
        ext = {{TAP_BITS{1'b0}}, coord};
        return ext[TAP_BITS-1:0];
    endfunction

endpackage

@@ sv/tsc_classify.sv @@
module tsc_classify (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              rel_valid,
    output logic                              rel_ready,
    input  tsc_pkg::release_t                 rel,
    input  logic [tsc_pkg::RAD2_BITS-1:0]     rad2,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_gesture,
    output logic [tsc_pkg::TAP_BITS-1:0]      m_tap_x,
    output logic [tsc_pkg::TAP_BITS-1:0]      m_tap_y
);

    // Stage one: the release as taken from the front end
    logic               s1_valid_reg;
    tsc_pkg::release_t  s1_reg;

    // Stage two: squared travel and the dominant axis
    logic                           s2_valid_reg;
    logic [tsc_pkg::SQ_BITS-1:0]    sq_x_reg;
    logic [tsc_pkg::SQ_BITS-1:0]    sq_y_reg;
    logic                           x_major_reg;
    logic                           s2_dx_neg_reg;
    logic                           s2_dy_pos_reg;
    tsc_pkg::tap_t                  s2_tap_x_reg;
    tsc_pkg::tap_t                  s2_tap_y_reg;

    // Result register
    logic               out_valid_reg;
    tsc_pkg::gesture_t  gesture_reg;
    tsc_pkg::tap_t      tap_x_reg;
    tsc_pkg::tap_t      tap_y_reg;

    logic s1_ready;
    logic s2_ready;
    logic out_ready;

    logic [tsc_pkg::SQ_BITS-1:0]    sq_x_next;
    logic [tsc_pkg::SQ_BITS-1:0]    sq_y_next;
    logic                           x_major_next;
    logic [tsc_pkg::DIST_BITS-1:0]  dist2;
    logic                           swipe;
    tsc_pkg::gesture_t              gesture_next;
    tsc_pkg::tap_t                  tap_x_next;
    tsc_pkg::tap_t                  tap_y_next;

    // Each stage moves on when it is empty or the stage after it moves on.
    assign out_ready = !out_valid_reg || m_ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign rel_ready = s1_ready;

    // Squares of the travel on each axis, and which axis dominates.
    assign sq_x_next    = tsc_pkg::SQ_BITS'(s1_reg.abs_dx) * tsc_pkg::SQ_BITS'(s1_reg.abs_dx);
    assign sq_y_next    = tsc_pkg::SQ_BITS'(s1_reg.abs_dy) * tsc_pkg::SQ_BITS'(s1_reg.abs_dy);
    assign x_major_next = s1_reg.abs_dx > s1_reg.abs_dy;

    // Travel against the radius, then direction; ties go to the vertical axis.
    always_comb begin
        dist2 = tsc_pkg::DIST_BITS'(sq_x_reg) + tsc_pkg::DIST_BITS'(sq_y_reg);
        swipe = tsc_pkg::CMP_BITS'(dist2) > tsc_pkg::CMP_BITS'(rad2);
        tap_x_next = '0;
        tap_y_next = '0;
        if (!swipe) begin
            gesture_next = tsc_pkg::GEST_TAP;
            tap_x_next   = s2_tap_x_reg;
            tap_y_next   = s2_tap_y_reg;
        end else if (x_major_reg) begin
            gesture_next = s2_dx_neg_reg ? tsc_pkg::GEST_LEFT : tsc_pkg::GEST_RIGHT;
        end else begin
            gesture_next = s2_dy_pos_reg ? tsc_pkg::GEST_DOWN : tsc_pkg::GEST_UP;
        end
    end

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= rel_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers load whenever their stage moves on.
    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_reg <= rel;
        end
        if (s2_ready) begin
            sq_x_reg      <= sq_x_next;
            sq_y_reg      <= sq_y_next;
            x_major_reg   <= x_major_next;
            s2_dx_neg_reg <= s1_reg.dx_neg;
            s2_dy_pos_reg <= s1_reg.dy_pos;
            s2_tap_x_reg  <= s1_reg.tap_x;
            s2_tap_y_reg  <= s1_reg.tap_y;
        end
        if (out_ready) begin
            gesture_reg <= gesture_next;
            tap_x_reg   <= tap_x_next;
            tap_y_reg   <= tap_y_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_gesture = gesture_reg;
    assign m_tap_x   = tap_x_reg;
    assign m_tap_y   = tap_y_reg;

endmodule

@@ sv/touch_swipe_classifier.sv @@
// Touch swipe classifier.
// Input channel (s_valid/s_ready, s_event_class, s_event_value) carries
// touch-panel events: absolute X, absolute Y, and touch key press/release.
// X and Y events update the latest coordinates; a press latches them as the
// start point. Only a release produces a result on the output channel
// (m_valid/m_ready, m_gesture, m_tap_x, m_tap_y): a tap with the release
// coordinates, or a swipe direction with zero coordinates.
// cfg_wr_en/cfg_wr_data write the swipe radius; write it only while idle.
// Throughput is one event per cycle while s_ready is high. A release
// passes through a three-stage pipeline whose middle stage holds the two
// squaring multipliers; other events finish in the transfer cycle.
// Reset clears the coordinates to 0, sets the radius to 50 and empties the
// pipeline. When the receiver stalls the result is held, the pipeline
// fills behind it and s_ready falls once all three stages are occupied.
module touch_swipe_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_event_class,
    input  logic [tsc_pkg::VALUE_BITS-1:0]  s_event_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_gesture,
    output logic [tsc_pkg::TAP_BITS-1:0]    m_tap_x,
    output logic [tsc_pkg::TAP_BITS-1:0]    m_tap_y,
    input  logic                            cfg_wr_en,
    input  logic [tsc_pkg::RADIUS_BITS-1:0] cfg_wr_data
);

    tsc_pkg::coord_t                    cur_x_reg;
    tsc_pkg::coord_t                    cur_y_reg;
    tsc_pkg::coord_t                    press_x_reg;
    tsc_pkg::coord_t                    press_y_reg;
    logic [tsc_pkg::RAD2_BITS-1:0]      rad2_reg;

    logic                               in_xfer;
    logic                               is_press;
    logic                               is_release;
    logic signed [tsc_pkg::COORD_BITS:0] dx;
    logic signed [tsc_pkg::COORD_BITS:0] dy;
    logic [tsc_pkg::COORD_BITS:0]       abs_dx_full;
    logic [tsc_pkg::COORD_BITS:0]       abs_dy_full;
    tsc_pkg::release_t                  rel;
    logic                               rel_ready;

    assign in_xfer    = s_valid && s_ready;
    assign is_press   = (s_event_class == tsc_pkg::EV_TOUCH) &&
                        (s_event_value == tsc_pkg::KEY_PRESS);
    assign is_release = (s_event_class == tsc_pkg::EV_TOUCH) &&
                        (s_event_value == tsc_pkg::KEY_RELEASE);

    // Travel from the start point to the latest coordinates.
    always_comb begin
        dx = $signed({1'b0, cur_x_reg}) - $signed({1'b0, press_x_reg});
        dy = $signed({1'b0, cur_y_reg}) - $signed({1'b0, press_y_reg});
        abs_dx_full = dx[tsc_pkg::COORD_BITS] ? -dx : dx;
        abs_dy_full = dy[tsc_pkg::COORD_BITS] ? -dy : dy;
        rel.abs_dx = abs_dx_full[tsc_pkg::COORD_BITS-1:0];
        rel.abs_dy = abs_dy_full[tsc_pkg::COORD_BITS-1:0];
        rel.dx_neg = dx[tsc_pkg::COORD_BITS];
        rel.dy_pos = !dy[tsc_pkg::COORD_BITS] && (dy != '0);
        rel.tap_x  = tsc_pkg::to_tap(cur_x_reg);
        rel.tap_y  = tsc_pkg::to_tap(cur_y_reg);
    end

    // Coordinate state is updated at the transfer of each event.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            press_x_reg <= '0;
            press_y_reg <= '0;
        end else if (in_xfer) begin
            if (s_event_class == tsc_pkg::EV_ABS_X) begin
                cur_x_reg <= tsc_pkg::to_coord(s_event_value);
            end
            if (s_event_class == tsc_pkg::EV_ABS_Y) begin
                cur_y_reg <= tsc_pkg::to_coord(s_event_value);
            end
            if (is_press) begin
                press_x_reg <= cur_x_reg;
                press_y_reg <= cur_y_reg;
            end
        end
    end

    // The radius is kept in squared form, worked out when it is written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rad2_reg <= tsc_pkg::RAD2_RESET;
        end else if (cfg_wr_en) begin
            rad2_reg <= tsc_pkg::RAD2_BITS'(cfg_wr_data) * tsc_pkg::RAD2_BITS'(cfg_wr_data);
        end
    end

    assign s_ready = rel_ready;

    tsc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rel_valid (in_xfer && is_release),
        .rel_ready (rel_ready),
        .rel       (rel),
        .rad2      (rad2_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_gesture (m_gesture),
        .m_tap_x   (m_tap_x),
        .m_tap_y   (m_tap_y)
    );

endmodule

@@ sv/tsc_checker.sv @@
module tsc_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [2:0]                      m_gesture,
    input  logic [tsc_pkg::TAP_BITS-1:0]    m_tap_x,
    input  logic [tsc_pkg::TAP_BITS-1:0]    m_tap_y
);

    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // A swipe carries zero coordinates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_gesture != tsc_pkg::GEST_TAP) |-> (m_tap_x == '0) && (m_tap_y == '0))
        else $error("swipe with nonzero coordinates");

    // The input is held off only while a result waits on a stalled receiver.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a stalled result");

endmodule

bind touch_swipe_classifier tsc_checker u_tsc_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_EVENTS   = 290;

    // One gesture report as it appears on the result channel
    typedef struct packed {
        gesture_t gesture;
        tap_t     x;
        tap_t     y;
    } gesture_report_t;

    // One line of the directed script; typed reports are known by inspection
    typedef struct packed {
        event_class_t           cls;
        logic [VALUE_BITS-1:0]  value;
        logic                   typed;
        gesture_report_t        report;
    } script_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    event_class_t           s_event_class;
    logic [VALUE_BITS-1:0]  s_event_value;
    logic                   m_valid;
    logic                   m_ready;
    logic [2:0]             m_gesture;
    tap_t                   m_tap_x;
    tap_t                   m_tap_y;
    logic                   cfg_wr_en;
    logic [RADIUS_BITS-1:0] cfg_wr_data;

    // Mirror of the block's state
    coord_t                 pos_x, pos_y;
    coord_t                 anchor_x, anchor_y;
    logic [RADIUS_BITS-1:0] radius_now;

    gesture_report_t        gestures_due[$];
    logic                   use_typed;
    gesture_report_t        typed_report;
    int                     errors;
    int                     events_sent;
    int                     idle_cycles;
    int unsigned            sender_idle_pct;
    int unsigned            sink_stall_pct;

    script_row_t script_rows [24] = '{
        '{EV_TOUCH, KEY_RELEASE,   1'b1, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_OTHER, 12'hFFF,       1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_TOUCH, 12'd2,         1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_TOUCH, 12'hFFF,       1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_ABS_X, 12'hFFF,       1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_ABS_Y, 12'hFFF,       1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_TOUCH, KEY_RELEASE,   1'b1, '{GEST_DOWN,  12'd0,    12'd0}},
        '{EV_TOUCH, KEY_PRESS,     1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_ABS_X, 12'd0,         1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_TOUCH, KEY_RELEASE,   1'b1, '{GEST_LEFT,  12'd0,    12'd0}},
        '{EV_ABS_X, 12'hFFF,       1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_ABS_Y, 12'd0,         1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_TOUCH, KEY_RELEASE,   1'b1, '{GEST_UP,    12'd0,    12'd0}},
        '{EV_TOUCH, KEY_PRESS,     1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_ABS_X, 12'd4045,      1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_TOUCH, KEY_RELEASE,   1'b1, '{GEST_TAP,   12'd4045, 12'd0}},
        '{EV_ABS_X, 12'd4044,      1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_TOUCH, KEY_RELEASE,   1'b1, '{GEST_LEFT,  12'd0,    12'd0}},
        '{EV_ABS_X, 12'd100,       1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_ABS_Y, 12'd100,       1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_TOUCH, KEY_PRESS,     1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_ABS_X, 12'd130,       1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_ABS_Y, 12'd141,       1'b0, '{GEST_TAP,   12'd0,    12'd0}},
        '{EV_TOUCH, KEY_RELEASE,   1'b0, '{GEST_TAP,   12'd0,    12'd0}}
    };

    touch_swipe_classifier dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_event_class (s_event_class),
        .s_event_value (s_event_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gesture     (m_gesture),
        .m_tap_x       (m_tap_x),
        .m_tap_y       (m_tap_y),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // 100 MHz clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Work out the gesture for one event and update the mirrored state.
    // Returns 1 when the event is a release and so yields a report.
    function automatic bit classify_touch(input event_class_t cls,
                                          input logic [VALUE_BITS-1:0] value,
                                          output gesture_report_t rep);
        int     dx, dy, ax, ay;
        longint dist2, rad2;
        rep = '0;
        case (cls)
            EV_ABS_X: begin
                pos_x = coord_t'(value);
                return 1'b0;
            end
            EV_ABS_Y: begin
                pos_y = coord_t'(value);
                return 1'b0;
            end
            EV_TOUCH: begin
                if (value == KEY_PRESS) begin
                    anchor_x = pos_x;
                    anchor_y = pos_y;
                    return 1'b0;
                end
                if (value != KEY_RELEASE) begin
                    return 1'b0;
                end
            end
            default: begin
                return 1'b0;
            end
        endcase
        dx    = int'(pos_x) - int'(anchor_x);
        dy    = int'(pos_y) - int'(anchor_y);
        ax    = (dx < 0) ? -dx : dx;
        ay    = (dy < 0) ? -dy : dy;
        dist2 = longint'(ax) * ax + longint'(ay) * ay;
        rad2  = longint'(radius_now) * radius_now;
        if (dist2 > rad2) begin
            // Ties in magnitude count as vertical travel.
            if (ax > ay) begin
                rep.gesture = (dx > 0) ? GEST_RIGHT : GEST_LEFT;
            end else begin
                rep.gesture = (dy > 0) ? GEST_DOWN : GEST_UP;
            end
        end else begin
            rep.gesture = GEST_TAP;
            rep.x       = tap_t'(pos_x);
            rep.y       = tap_t'(pos_y);
        end
        return 1'b1;
    endfunction

    // Receiver: ready is withheld at random according to the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Predict on every input transfer, check every result transfer, and
    // end the run if the block stops moving data.
    always @(posedge aclk) begin
        gesture_report_t predicted;
        gesture_report_t want;
        bit              produced;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                produced = classify_touch(s_event_class, s_event_value, predicted);
                if (use_typed) begin
                    gestures_due.push_back(typed_report);
                end else if (produced) begin
                    gestures_due.push_back(predicted);
                end
            end
            if (m_valid && m_ready) begin
                if (gestures_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got gesture %0d x %0d y %0d",
                             $time, m_gesture, m_tap_x, m_tap_y);
                    errors++;
                end else begin
                    want = gestures_due.pop_front();
                    if (m_gesture !== want.gesture) begin
                        $display("%0t: gesture mismatch: expected %0d, got %0d",
                                 $time, want.gesture, m_gesture);
                        errors++;
                    end
                    if (m_tap_x !== want.x) begin
                        $display("%0t: tap_x mismatch: expected %0d, got %0d",
                                 $time, want.x, m_tap_x);
                        errors++;
                    end
                    if (m_tap_y !== want.y) begin
                        $display("%0t: tap_y mismatch: expected %0d, got %0d",
                                 $time, want.y, m_tap_y);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Hold off the sender until every outstanding report has come back,
    // then let the pipeline settle. Called at a falling edge.
    task automatic drain_results();
        s_valid = 1'b0;
        @(negedge aclk);
        while (gestures_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Present one event and wait for its transfer. Called at a falling edge
    // and returns at a falling edge.
    task automatic send_event(input event_class_t cls, input logic [VALUE_BITS-1:0] value);
        if ($urandom_range(0, 149) == 0) begin
            drain_results();
        end
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_event_class = cls;
        s_event_value = value;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
        if (!(cls == EV_OTHER ||
              (cls == EV_TOUCH && value != KEY_PRESS && value != KEY_RELEASE))) begin
            events_sent++;
        end
    endtask

    // Change the swipe radius with the block idle.
    task automatic set_radius(input logic [RADIUS_BITS-1:0] radius);
        drain_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = radius;
        radius_now  = radius;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // Coordinates lean towards the panel edges now and then.
    function automatic coord_t pick_coord();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return '0;
        end
        if (sel == 1) begin
            return '1;
        end
        return coord_t'($urandom_range(0, (1 << COORD_BITS) - 1));
    endfunction

    function automatic coord_t nudge(input coord_t base, input int delta);
        int v;
        v = int'(base) + delta;
        if (v < 0) begin
            v = 0;
        end
        if (v > (1 << COORD_BITS) - 1) begin
            v = (1 << COORD_BITS) - 1;
        end
        return coord_t'(v);
    endfunction

    // A touch: position, usually a press, up to three moves, release.
    task automatic play_gesture();
        coord_t      x, y;
        int          span, dx, dy;
        int unsigned moves, mode;
        x = pick_coord();
        y = pick_coord();
        if ($urandom_range(0, 1)) begin
            send_event(EV_ABS_X, x);
            send_event(EV_ABS_Y, y);
        end else begin
            send_event(EV_ABS_Y, y);
            send_event(EV_ABS_X, x);
        end
        // Occasionally release without pressing first.
        if ($urandom_range(0, 19) != 0) begin
            send_event(EV_TOUCH, KEY_PRESS);
        end
        moves = $urandom_range(0, 3);
        for (int i = 0; i < moves; i++) begin
            span = int'(radius_now) + 16;
            if (span > 4095) begin
                span = 4095;
            end
            mode = $urandom_range(0, 3);
            dx = int'($urandom_range(0, 2 * span)) - span;
            dy = int'($urandom_range(0, 2 * span)) - span;
            case (mode)
                0: begin
                    // Short travel, mostly taps.
                    x = nudge(x, dx / 2);
                    y = nudge(y, dy / 2);
                end
                1: begin
                    x = nudge(x, dx);
                    y = nudge(y, dy);
                end
                2: begin
                    // Diagonal travel with equal magnitudes.
                    x = nudge(x, dx);
                    y = nudge(y, $urandom_range(0, 1) ? dx : -dx);
                end
                default: begin
                    x = pick_coord();
                    y = pick_coord();
                end
            endcase
            if ($urandom_range(0, 3) != 0) begin
                send_event(EV_ABS_X, x);
            end
            if ($urandom_range(0, 3) != 0) begin
                send_event(EV_ABS_Y, y);
            end
        end
        send_event(EV_TOUCH, KEY_RELEASE);
    endtask

    // Stray events: any class, with a value that is a release, a press or random.
    task automatic send_noise();
        event_class_t          cls;
        logic [VALUE_BITS-1:0] value;
        cls = event_class_t'(2'($urandom_range(0, 3)));
        case ($urandom_range(0, 2))
            0: value = KEY_RELEASE;
            1: value = KEY_PRESS;
            default: value = VALUE_BITS'($urandom_range(0, (1 << VALUE_BITS) - 1));
        endcase
        send_event(cls, value);
    endtask

    initial begin
        int target;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_event_class   = EV_OTHER;
        s_event_value   = '0;
        m_ready         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        use_typed       = 1'b0;
        typed_report    = '0;
        errors          = 0;
        events_sent     = 0;
        idle_cycles     = 0;
        sender_idle_pct = 0;
        sink_stall_pct  = 0;
        pos_x           = '0;
        pos_y           = '0;
        anchor_x        = '0;
        anchor_y        = '0;
        radius_now      = RADIUS_RESET;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed script at the reset radius
        foreach (script_rows[i]) begin
            use_typed    = script_rows[i].typed;
            typed_report = script_rows[i].report;
            send_event(script_rows[i].cls, script_rows[i].value);
        end
        use_typed = 1'b0;

        // Random phases, each with its own radius and a flow-control pattern
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    set_radius('0);
                    sender_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
                1: begin
                    set_radius('1);
                    sender_idle_pct = 71;
                    sink_stall_pct  = 0;
                end
                2: begin
                    set_radius(RADIUS_BITS'(1));
                    sender_idle_pct = 0;
                    sink_stall_pct  = 71;
                end
                3: begin
                    set_radius(RADIUS_BITS'($urandom_range(0, 4095)));
                    sender_idle_pct = 28;
                    sink_stall_pct  = 28;
                end
                4: begin
                    set_radius(RADIUS_RESET);
                    sender_idle_pct = 71;
                    sink_stall_pct  = 71;
                end
                default: begin
                    set_radius(RADIUS_BITS'($urandom_range(2, 400)));
                    sender_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
            endcase
            target = events_sent + PHASE_EVENTS;
            while (events_sent < target) begin
                if ($urandom_range(0, 99) < 12) begin
                    send_noise();
                end else begin
                    play_gesture();
                end
            end
        end

        drain_results();
        if (errors == 0 && gestures_due.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
